/* rtl/sst_pkg.sv */
// Shared types, widths and the reserved word table of the syntax span tokenizer.
`default_nettype none

package sst_pkg;

    // Default sizing of the line and of the word buffer.
    localparam int LINE_MAX_DEF = 4096;
    localparam int WORD_MAX_DEF = 8;

    // Fixed widths of the item fields.
    localparam int CH_W          = 8;
    localparam int SPAN_START_W  = 12;
    localparam int SPAN_LENGTH_W = 13;
    localparam int SPAN_CLASS_W  = 2;

    // Span classes.
    localparam logic [SPAN_CLASS_W-1:0] CLASS_WORD      = 2'd0;
    localparam logic [SPAN_CLASS_W-1:0] CLASS_STRING    = 2'd1;
    localparam logic [SPAN_CLASS_W-1:0] CLASS_COMMENT   = 2'd2;
    localparam logic [SPAN_CLASS_W-1:0] CLASS_DIRECTIVE = 2'd3;

    // Reserved word table. The longest entry fits in KW_CHARS characters.
    localparam int KW_COUNT = 25;
    localparam int KW_CHARS = 8;
    localparam int KW_LEN_W = 4;

    // Each word is held with its first character in the low byte, so the
    // literals below read backwards. Unused high bytes are zero.
    localparam logic [KW_CHARS*8-1:0] KW_TEXT [KW_COUNT] = '{
        64'("od"),       64'("fi"),       64'("ni"),       64'("rof"),
        64'("wen"),      64'("mun"),      64'("fer"),      64'("esle"),
        64'("siht"),     64'("nehw"),     64'("kaerb"),    64'("ssalc"),
        64'("tsnoc"),    64'("elihw"),    64'("eteled"),   64'("ravjbo"),
        64'("nruter"),   64'("citats"),   64'("gnirts"),   64'("amgarp#"),
        64'("sdnetxe"),  64'("hcaerof"),  64'("edulcni#"), 64'("eunitnoc"),
        64'("noitcnuf")
    };

    localparam logic [KW_LEN_W-1:0] KW_LEN [KW_COUNT] = '{
        4'd2, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4, 4'd4,
        4'd5, 4'd5, 4'd5, 4'd5, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd7,
        4'd7, 4'd7, 4'd8, 4'd8, 4'd8
    };

    // One reported span.
    typedef struct packed {
        logic                     to_line_end;
        logic [SPAN_CLASS_W-1:0]  span_class;
        logic [SPAN_LENGTH_W-1:0] span_length;
        logic [SPAN_START_W-1:0]  span_start;
    } span_t;

endpackage

`default_nettype wire

/* rtl/sst_kw_match.sv */
// Parallel compare of a buffered word against the reserved word table.
`default_nettype none

module sst_kw_match #(
    parameter int WORD_MAX = sst_pkg::WORD_MAX_DEF,
    parameter int WL_W     = $clog2(WORD_MAX + 1)
) (
    input  wire logic [sst_pkg::KW_CHARS*8-1:0] word_text,
    input  wire logic [WL_W-1:0]                word_length,
    input  wire logic                           word_too_long,
    output logic                                match
);
    import sst_pkg::*;

    logic [KW_COUNT-1:0] hit;

    // Bytes past the word length are zero, so a whole-entry compare plus a
    // length check gives an exact match.
    always_comb
    begin
        for (int k = 0; k < KW_COUNT; k++)
        begin
            hit[k] = (word_length == WL_W'(KW_LEN[k])) && (word_text == KW_TEXT[k]);
        end
    end

    assign match = !word_too_long && (|hit);

endmodule

`default_nettype wire

/* rtl/sst_scan_core.sv */
// Scanner state and the per-character mode update that produces spans.
`default_nettype none

module sst_scan_core #(
    parameter int LINE_MAX = sst_pkg::LINE_MAX_DEF,
    parameter int WORD_MAX = sst_pkg::WORD_MAX_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     accept,
    input  wire logic [sst_pkg::CH_W-1:0] ch,
    input  wire logic                     line_last,
    output logic                          emit,
    output sst_pkg::span_t                span
);
    import sst_pkg::*;

    localparam int COL_W = $clog2(LINE_MAX);
    localparam int WL_W  = $clog2(WORD_MAX + 1);
    localparam int IDX_W = $clog2(WORD_MAX);

    // Scan modes.
    localparam logic [2:0] M_IDLE  = 3'd0;
    localparam logic [2:0] M_WORD  = 3'd1;
    localparam logic [2:0] M_STR   = 3'd2;
    localparam logic [2:0] M_ESC   = 3'd3;
    localparam logic [2:0] M_SLASH = 3'd4;
    localparam logic [2:0] M_BANG  = 3'd5;
    localparam logic [2:0] M_SKIP  = 3'd6;

    // Characters with a meaning of their own.
    localparam logic [CH_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CH_W-1:0] CH_UNDER  = 8'h5F;
    localparam logic [CH_W-1:0] CH_HASH   = 8'h23;
    localparam logic [CH_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [CH_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CH_W-1:0] CH_BANG   = 8'h21;
    localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;

    // Latin-1 letters.
    function automatic logic is_letter(input logic [CH_W-1:0] c);
        is_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)
                 || c == 8'hAA || c == 8'hB5 || c == 8'hBA
                 || (c >= 8'hC0 && c != 8'hD7 && c != 8'hF7);
    endfunction

    // Latin-1 digits, including superscripts and fractions.
    function automatic logic is_number(input logic [CH_W-1:0] c);
        is_number = (c >= 8'h30 && c <= 8'h39) || c == 8'hB2 || c == 8'hB3
                 || c == 8'hB9 || (c >= 8'hBC && c <= 8'hBE);
    endfunction

    logic [2:0]                  mode_reg, mode_p, mode_next;
    logic [COL_W-1:0]            col_reg, col_next;
    logic [COL_W-1:0]            tok_reg, tok_p;
    logic [WORD_MAX-1:0][7:0]    word_buf_reg, word_buf_p, word_buf_next;
    logic [WL_W-1:0]             wlen_reg, wlen_p, wlen_next;
    logic                        long_reg, long_p, long_next;
    logic                        emit_p, reexam;
    span_t                       span_p;
    logic                        match_cur, match_p;
    logic                        word_start, word_cont;
    logic [COL_W:0]              str_len;

    assign word_start = is_letter(ch) || ch == CH_DOLLAR || ch == CH_UNDER || ch == CH_HASH;
    assign word_cont  = is_letter(ch) || is_number(ch) || ch == CH_DOLLAR || ch == CH_UNDER;
    assign str_len    = {1'b0, col_reg} - {1'b0, tok_reg} + (COL_W+1)'(1);

    // Match of the word held before this character, and of the word after it.
    sst_kw_match #(.WORD_MAX(WORD_MAX), .WL_W(WL_W)) u_match_cur (
        .word_text     (word_buf_reg[KW_CHARS-1:0]),
        .word_length   (wlen_reg),
        .word_too_long (long_reg),
        .match         (match_cur)
    );

    sst_kw_match #(.WORD_MAX(WORD_MAX), .WL_W(WL_W)) u_match_p (
        .word_text     (word_buf_p[KW_CHARS-1:0]),
        .word_length   (wlen_p),
        .word_too_long (long_p),
        .match         (match_p)
    );

    // Mode update for one character, with the second look in idle mode when
    // a token ends on a character that does not belong to it.
    always_comb
    begin
        mode_p     = mode_reg;
        tok_p      = tok_reg;
        word_buf_p = word_buf_reg;
        wlen_p     = wlen_reg;
        long_p     = long_reg;
        emit_p     = 1'b0;
        span_p     = '0;
        reexam     = 1'b0;
        case (mode_reg)
            M_IDLE:
            begin
                reexam = 1'b1;
            end
            M_WORD:
            begin
                if (word_cont)
                begin
                    if (wlen_reg < WL_W'(WORD_MAX))
                    begin
                        word_buf_p[wlen_reg[IDX_W-1:0]] = ch;
                        wlen_p = wlen_reg + WL_W'(1);
                    end
                    else
                    begin
                        long_p = 1'b1;
                    end
                end
                else
                begin
                    if (match_cur)
                    begin
                        emit_p             = 1'b1;
                        span_p.span_start  = SPAN_START_W'(tok_reg);
                        span_p.span_length = SPAN_LENGTH_W'(wlen_reg);
                        span_p.span_class  = CLASS_WORD;
                    end
                    reexam = 1'b1;
                end
            end
            M_STR:
            begin
                if (ch == CH_QUOTE)
                begin
                    emit_p             = 1'b1;
                    span_p.span_start  = SPAN_START_W'(tok_reg);
                    span_p.span_length = SPAN_LENGTH_W'(str_len);
                    span_p.span_class  = CLASS_STRING;
                    mode_p             = M_IDLE;
                end
                else if (ch == CH_BSLASH)
                begin
                    mode_p = M_ESC;
                end
            end
            M_ESC:
            begin
                mode_p = M_STR;
            end
            M_SLASH:
            begin
                if (ch == CH_SLASH)
                begin
                    emit_p             = 1'b1;
                    span_p.span_start  = SPAN_START_W'(tok_reg);
                    span_p.span_class  = CLASS_COMMENT;
                    span_p.to_line_end = 1'b1;
                    mode_p             = M_SKIP;
                end
                else
                begin
                    reexam = 1'b1;
                end
            end
            M_BANG:
            begin
                if (ch == CH_BANG)
                begin
                    emit_p             = 1'b1;
                    span_p.span_class  = CLASS_DIRECTIVE;
                    span_p.to_line_end = 1'b1;
                    mode_p             = M_SKIP;
                end
                else
                begin
                    reexam = 1'b1;
                end
            end
            M_SKIP:
            begin
                mode_p = M_SKIP;
            end
            default:
            begin
                reexam = 1'b1;
            end
        endcase

        // Idle mode: the character may open a new token.
        if (reexam)
        begin
            mode_p = M_IDLE;
            if (word_start)
            begin
                mode_p        = M_WORD;
                tok_p         = col_reg;
                word_buf_p    = '0;
                word_buf_p[0] = ch;
                wlen_p        = WL_W'(1);
                long_p        = 1'b0;
            end
            else if (ch == CH_QUOTE)
            begin
                mode_p = M_STR;
                tok_p  = col_reg;
            end
            else if (ch == CH_SLASH)
            begin
                mode_p = M_SLASH;
                tok_p  = col_reg;
            end
            else if (col_reg == '0 && ch == CH_BANG)
            begin
                mode_p = M_BANG;
            end
        end
    end

    // Line end: a pending reserved word is reported and the line state is cleared.
    always_comb
    begin
        emit          = emit_p;
        span          = span_p;
        mode_next     = mode_p;
        word_buf_next = word_buf_p;
        wlen_next     = wlen_p;
        long_next     = long_p;
        col_next      = col_reg;
        if (line_last)
        begin
            if (mode_p == M_WORD && !emit_p && match_p)
            begin
                emit             = 1'b1;
                span             = '0;
                span.span_start  = SPAN_START_W'(tok_p);
                span.span_length = SPAN_LENGTH_W'(wlen_p);
                span.span_class  = CLASS_WORD;
            end
            mode_next     = M_IDLE;
            col_next      = '0;
            wlen_next     = '0;
            long_next     = 1'b0;
            word_buf_next = '0;
        end
        else if (col_reg != COL_W'(LINE_MAX - 1))
        begin
            col_next = col_reg + COL_W'(1);
        end
    end

    // Scanner state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= M_IDLE;
            col_reg      <= '0;
            tok_reg      <= '0;
            word_buf_reg <= '0;
            wlen_reg     <= '0;
            long_reg     <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg     <= mode_next;
            col_reg      <= col_next;
            tok_reg      <= tok_p;
            word_buf_reg <= word_buf_next;
            wlen_reg     <= wlen_next;
            long_reg     <= long_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/sst_span_queue.sv */
// Two-entry result register with skid stage toward the output stream.
`default_nettype none

module sst_span_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire sst_pkg::span_t push_span,
    output logic                space,
    output logic                out_valid,
    input  wire logic           out_ready,
    output sst_pkg::span_t      out_span
);
    import sst_pkg::*;

    span_t main_reg, skid_reg;
    logic  main_valid_reg, skid_valid_reg;
    logic  pop;

    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_span  = main_reg;
    assign pop       = main_valid_reg && out_ready;

    // Valid flags; a push arrives only while the skid stage is empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            main_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    // Payload moves without reset.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_reg <= push_span;
            end
            else
            begin
                main_reg <= push_span;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/syntax_span_tokenizer_unit.sv */
// Top level of the syntax span tokenizer: input stream, scanner and span output stream.
`default_nettype none

// The block takes one Latin-1 character of a source line per input item, with
// tlast marking the last character of the line, and reports highlight spans
// for reserved words, double-quoted strings, '//' comments and lines that open
// with '!!'. One item is taken every cycle while the output register has
// room: the mode update and the compare against all 25 reserved words sit in
// one pass of logic behind the scanner state registers. A character gives at
// most one span; spans enter a two-entry output register, so input is held off
// only while both entries are full. A span is registered into the main entry,
// or the skid entry while the main one waits. Columns saturate at LINE_MAX-1,
// and words longer than WORD_MAX characters never match.
module syntax_span_tokenizer_unit #(
    parameter int LINE_MAX = sst_pkg::LINE_MAX_DEF,
    parameter int WORD_MAX = sst_pkg::WORD_MAX_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [11:0] span_start, [24:12] span_length
    output logic [2:0]       m_axis_tuser    // [1:0] span_class, [2] to_line_end
);
    import sst_pkg::*;

    logic  accept, emit, space;
    span_t span, out_span;

    assign s_axis_tready = space;
    assign accept        = s_axis_tvalid && space;

    sst_scan_core #(.LINE_MAX(LINE_MAX), .WORD_MAX(WORD_MAX)) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .ch        (s_axis_tdata),
        .line_last (s_axis_tlast),
        .emit      (emit),
        .span      (span)
    );

    sst_span_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && emit),
        .push_span (span),
        .space     (space),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_span  (out_span)
    );

    // Output packing.
    assign m_axis_tdata = {7'b0, out_span.span_length, out_span.span_start};
    assign m_axis_tuser = {out_span.to_line_end, out_span.span_class};

endmodule

`default_nettype wire
